### sv/okl_pkg.sv
package okl_pkg;

    localparam int KEY_W       = 32;
    localparam int OUT_COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_PREPEND = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_REMOVE  = 2'd3
    } t_opcode;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic push_tail;
        logic push_head;
        logic del_scan;
    } t_cell_ctl;

endpackage

### sv/ordered_key_list_engine.sv
// Channel   Transfer when        Ports
// --------  -------------------  ---------------------------------------------
// command   start && !busy       i_opcode, i_order_key
// result    o_done (one cycle)   o_found, o_status, o_entry_count
//
// Append and prepend: result in the cycle after the transfer; busy stays low,
// so one insert may follow every cycle.
// Search and remove: a token walks the row of DEPTH cells one per cycle; the
// result is registered when the token reaches the last cell; busy is high while it walks.
// Synchronous active-low reset empties the list; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ordered_key_list_engine
    import okl_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_opcode,
    input  logic signed [KEY_W-1:0] i_order_key,
    output logic                   o_done,
    output logic                   o_found,
    output logic [1:0]             o_status,
    output logic [OUT_COUNT_W-1:0] o_entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [KEY_W-1:0] r_key;
    logic             r_del;
    logic [CNT_W-1:0] r_count;
    logic             r_done;
    logic             r_found;
    logic [1:0]       r_status;

    t_opcode          op;
    logic             accept;
    logic             full;
    logic             is_scan_op;
    logic             scan_end;
    logic             scan_found;
    logic [KEY_W-1:0] bcast_key;
    t_cell_ctl        cell_ctl;

    logic [KEY_W-1:0] w_key  [DEPTH];
    logic             w_tok  [DEPTH];
    logic             w_seen [DEPTH];

    assign op         = t_opcode'(i_opcode);
    assign busy       = (r_state == S_SCAN);
    assign accept     = start && !busy;
    assign full       = (r_count == FULL_COUNT);
    assign is_scan_op = (op == OP_SEARCH) || (op == OP_REMOVE);
    assign scan_end   = w_tok[DEPTH-1];
    assign scan_found = w_seen[DEPTH-1];
    assign bcast_key  = busy ? r_key : KEY_W'(i_order_key);

    assign cell_ctl.push_tail = accept && (op == OP_APPEND) && !full;
    assign cell_ctl.push_head = accept && (op == OP_PREPEND) && !full;
    assign cell_ctl.del_scan  = busy && r_del;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && is_scan_op) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (accept && !is_scan_op) begin
                r_done <= 1'b1;
                if (!full) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (busy && scan_end) begin
                r_done <= 1'b1;
                if (r_del && scan_found) begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= KEY_W'(i_order_key);
            r_del <= (op == OP_REMOVE);
        end
        if (accept && !is_scan_op) begin
            r_found  <= 1'b0;
            r_status <= full ? ST_FULL : ST_OK;
        end else if (busy && scan_end) begin
            r_found  <= scan_found;
            r_status <= (r_del && !scan_found) ? ST_MISSING : ST_OK;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_W-1:0] left_key;
            logic [KEY_W-1:0] right_key;
            logic             tok_in;
            logic             seen_in;

            if (g == 0) begin : g_head
                assign left_key = bcast_key;
                assign tok_in   = accept && is_scan_op;
                assign seen_in  = 1'b0;
            end else begin : g_mid
                assign left_key = w_key[g-1];
                assign tok_in   = w_tok[g-1];
                assign seen_in  = w_seen[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign right_key = '0;
            end else begin : g_body
                assign right_key = w_key[g+1];
            end

            okl_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (cell_ctl),
                .i_key       (bcast_key),
                .i_count     (r_count),
                .i_left_key  (left_key),
                .i_right_key (right_key),
                .i_tok       (tok_in),
                .i_seen      (seen_in),
                .o_key       (w_key[g]),
                .o_tok       (w_tok[g]),
                .o_seen      (w_seen[g])
            );
        end
    endgenerate

    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_status      = r_status;
    assign o_entry_count = OUT_COUNT_W'(r_count);

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && busy))
        else $error("result strobe while scan still running");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("occupancy above depth");

    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_end |-> busy)
        else $error("scan token left the row outside a scan");

    a_insert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((op == OP_APPEND) || (op == OP_PREPEND))) |=> o_done)
        else $error("insert gave no result in the next cycle");

    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && scan_end) |=> (o_done && !busy))
        else $error("scan end gave no result");

endmodule

### sv/okl_cell.sv
module okl_cell
    import okl_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_key,
    input  logic [CNT_W-1:0] i_count,
    input  logic [KEY_W-1:0] i_left_key,
    input  logic [KEY_W-1:0] i_right_key,
    input  logic             i_tok,
    input  logic             i_seen,
    output logic [KEY_W-1:0] o_key,
    output logic             o_tok,
    output logic             o_seen
);

    localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

    logic [KEY_W-1:0] r_key;
    logic             r_tok;
    logic             r_seen;
    logic             occupied;
    logic             hit;
    logic             seen_here;

    assign occupied  = POS < i_count;
    assign hit       = r_tok && occupied && (r_key == i_key);
    assign seen_here = r_seen || hit;

    assign o_key  = r_key;
    assign o_tok  = r_tok;
    assign o_seen = seen_here;

    // Scan token walks one cell per cycle, carrying whether a match was met upstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_seen <= 1'b0;
        end else begin
            r_tok  <= i_tok;
            r_seen <= i_seen && i_tok;
        end
    end

    // Right neighbour has not been visited yet, so it still holds its old key
    always_ff @(posedge i_clk) begin
        if (i_ctl.push_head) begin
            r_key <= i_left_key;
        end else if (i_ctl.push_tail && (i_count == POS)) begin
            r_key <= i_key;
        end else if (i_ctl.del_scan && seen_here) begin
            r_key <= i_right_key;
        end
    end

endmodule
